// ===== rtl/rw_lock_table_with_waiters_assert.svh =====
// assertion macros for the lock table
// used by the top level only, needs a signal named clock and one named reset
`ifndef RW_LOCK_TABLE_WITH_WAITERS_ASSERT_SVH
`define RW_LOCK_TABLE_WITH_WAITERS_ASSERT_SVH

// condition implies consequence in the same cycle
`define RWLT_ASSERT_NOW(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("lock table check failed");

// condition implies consequence in the next cycle
`define RWLT_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("lock table check failed");

`endif

// ===== rtl/rwlt_pkg.sv =====
// shared types and codes of the lock table
// no dependencies
`timescale 1ns / 1ps

package rwlt_pkg;

   localparam int ENTRIES_DEF     = 1024;
   localparam int WAIT_DEPTH_DEF  = 16;
   localparam int MAX_READERS_DEF = 254;

   localparam logic [2:0] ACT_ACQ_RD = 3'd0;
   localparam logic [2:0] ACT_ACQ_WR = 3'd1;
   localparam logic [2:0] ACT_REL_RD = 3'd2;
   localparam logic [2:0] ACT_REL_WR = 3'd3;
   localparam logic [2:0] ACT_CANCEL = 3'd4;

   localparam logic [2:0] K_GRANT    = 3'd0;
   localparam logic [2:0] K_QUEUED   = 3'd1;
   localparam logic [2:0] K_FULL     = 3'd2;
   localparam logic [2:0] K_RELEASED = 3'd3;
   localparam logic [2:0] K_CANCEL   = 3'd4;
   localparam logic [2:0] K_NONE     = 3'd5;
   localparam logic [2:0] K_BAD      = 3'd6;

   localparam logic [7:0] WORD_IDLE  = 8'd0;
   localparam logic [7:0] WORD_WRITE = 8'd255;

   typedef struct packed {
      logic [2:0] action;
      logic [9:0] entry;
      logic [7:0] requester;
      logic [7:0] slot;
      logic       mode;
      logic       bad;
   } cmd_type;

   typedef struct packed {
      logic [9:0] entry;
      logic [7:0] requester;
      logic [7:0] slot;
      logic       mode;
   } waiter_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [9:0] entry;
      logic [7:0] requester;
      logic [7:0] slot;
      logic       mode;
   } res_type;

   // front to back handoff
   typedef struct packed {
      logic    avail;
      cmd_type head;
   } fq_type;

endpackage

// ===== rtl/rwlt_ram.sv =====
// generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rwlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rwlt_front.sv =====
// front part: accepts requests, classifies them, two deep queue to the back part
// depends on rwlt_pkg
`timescale 1ns / 1ps

module rwlt_front #(
   parameter int ENTRIES = rwlt_pkg::ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [2:0]       action,
   input  logic [9:0]       entry,
   input  logic [7:0]       requester,
   input  logic [7:0]       slot,
   input  logic [10:0]      entry_count,
   input  logic             pop,
   output logic             full,
   output rwlt_pkg::fq_type fq
);

   rwlt_pkg::cmd_type q_ff [2];
   rwlt_pkg::cmd_type q_in [2];
   rwlt_pkg::cmd_type cls;
   logic [1:0] cnt_ff, cnt_in, cnt_mid;

   always_comb begin
      cls.action    = action;
      cls.entry     = entry;
      cls.requester = requester;
      cls.slot      = slot;
      cls.mode      = (action < rwlt_pkg::ACT_CANCEL) ? action[0] : 1'b0;
      cls.bad       = (action > rwlt_pkg::ACT_CANCEL) || ({1'b0, entry} >= entry_count)
                      || (32'(entry) >= ENTRIES);
   end

   always_comb begin
      q_in    = q_ff;
      cnt_mid = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_mid = cnt_ff - 2'd1;
      end
      cnt_in = cnt_mid;
      if (push) begin
         q_in[cnt_mid[0]] = cls;
         cnt_in = cnt_mid + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

   assign full     = cnt_ff[1];
   assign fq.avail = (cnt_ff != 2'd0);
   assign fq.head  = q_ff[0];

endmodule

// ===== rtl/rwlt_back.sv =====
// back part: lock word memory, waiter queue and the sequencer that runs each command
// depends on rwlt_pkg and rwlt_ram
`timescale 1ns / 1ps

module rwlt_back #(
   parameter int ENTRIES     = rwlt_pkg::ENTRIES_DEF,
   parameter int WAIT_DEPTH  = rwlt_pkg::WAIT_DEPTH_DEF,
   parameter int MAX_READERS = rwlt_pkg::MAX_READERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rwlt_pkg::fq_type  fq,
   output logic              pop,
   output logic              clearing,
   output logic              out_valid,
   output logic              out_last,
   output rwlt_pkg::res_type out_res
);

   localparam int AW = $clog2(ENTRIES);
   localparam int PW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int CW = $clog2(WAIT_DEPTH + 1);
   localparam int CAP = (MAX_READERS < 254) ? MAX_READERS : 254;
   localparam logic [7:0] READ_CAP = 8'(CAP);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]           state_ff, state_in;
   rwlt_pkg::cmd_type    cur_ff, cur_in;
   logic [7:0]           word_ff, word_in;
   logic [CW-1:0]        p_ff, p_in, cnt_ff, cnt_in;
   logic                 first_ff, first_in, drop_ff, drop_in;
   logic [AW-1:0]        clr_ff, clr_in;
   rwlt_pkg::waiter_type q_ff [WAIT_DEPTH];
   rwlt_pkg::waiter_type q_in [WAIT_DEPTH];
   rwlt_pkg::res_type    pend_ff, pend_in, out_ff, out_in;
   logic                 out_v_ff, out_v_in, last_ff, last_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [7:0]           wr_data, rd_data;
   rwlt_pkg::waiter_type v;
   logic                 has_w, ok, remove;
   logic [7:0]           new_w;
   rwlt_pkg::res_type    echo;

   rwlt_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_words (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (AW'(fq.head.entry)),
      .rd_data (rd_data)
   );

   assign v = q_ff[p_ff[PW-1:0]];

   always_comb begin
      has_w = 1'b0;
      for (int i = 0; i < WAIT_DEPTH; i++) begin
         if ((CW'(i) < cnt_ff) && (q_ff[i].entry == cur_ff.entry)) begin
            has_w = 1'b1;
         end
      end
   end

   // hand-off decision for the waiter at the walk position
   always_comb begin
      ok    = 1'b0;
      new_w = word_ff;
      if (first_ff) begin
         if (cur_ff.mode) begin
            ok    = 1'b1;
            new_w = v.mode ? rwlt_pkg::WORD_WRITE : 8'd1;
         end else if (v.mode) begin
            ok    = (word_ff == 8'd1);
            new_w = rwlt_pkg::WORD_WRITE;
         end else begin
            ok = 1'b1;
         end
      end else if (v.mode) begin
         ok    = (word_ff == rwlt_pkg::WORD_IDLE);
         new_w = rwlt_pkg::WORD_WRITE;
      end else begin
         ok    = (word_ff != rwlt_pkg::WORD_WRITE) && (word_ff < READ_CAP);
         new_w = word_ff + 8'd1;
      end
   end

   always_comb begin
      echo.kind      = rwlt_pkg::K_BAD;
      echo.entry     = cur_ff.entry;
      echo.requester = cur_ff.requester;
      echo.slot      = cur_ff.slot;
      echo.mode      = cur_ff.mode;
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      word_in  = word_ff;
      p_in     = p_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      drop_in  = drop_ff;
      clr_in   = clr_ff;
      q_in     = q_ff;
      pend_in  = pend_ff;
      out_in   = out_ff;
      out_v_in = 1'b0;
      last_in  = 1'b0;
      pop      = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = AW'(cur_ff.entry);
      wr_data  = word_ff;
      remove   = 1'b0;
      case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = rwlt_pkg::WORD_IDLE;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (fq.avail) begin
               pop    = 1'b1;
               cur_in = fq.head;
               if (fq.head.bad) begin
                  out_v_in         = 1'b1;
                  last_in          = 1'b1;
                  out_in.kind      = rwlt_pkg::K_BAD;
                  out_in.entry     = fq.head.entry;
                  out_in.requester = fq.head.requester;
                  out_in.slot      = fq.head.slot;
                  out_in.mode      = fq.head.mode;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            p_in     = '0;
            first_in = 1'b1;
            drop_in  = 1'b0;
            word_in  = rd_data;
            out_in   = echo;
            case (cur_ff.action)
               rwlt_pkg::ACT_ACQ_RD, rwlt_pkg::ACT_ACQ_WR: begin
                  out_v_in = 1'b1;
                  last_in  = 1'b1;
                  state_in = S_IDLE;
                  if (rd_data == rwlt_pkg::WORD_IDLE) begin
                     wr_en       = 1'b1;
                     wr_data     = cur_ff.mode ? rwlt_pkg::WORD_WRITE : 8'd1;
                     out_in.kind = rwlt_pkg::K_GRANT;
                  end else if (!cur_ff.mode && rd_data != rwlt_pkg::WORD_WRITE
                               && rd_data < READ_CAP && !has_w) begin
                     wr_en       = 1'b1;
                     wr_data     = rd_data + 8'd1;
                     out_in.kind = rwlt_pkg::K_GRANT;
                  end else if (cnt_ff == CW'(WAIT_DEPTH)) begin
                     out_in.kind = rwlt_pkg::K_FULL;
                  end else begin
                     q_in[cnt_ff[PW-1:0]].entry     = cur_ff.entry;
                     q_in[cnt_ff[PW-1:0]].requester = cur_ff.requester;
                     q_in[cnt_ff[PW-1:0]].slot      = cur_ff.slot;
                     q_in[cnt_ff[PW-1:0]].mode      = cur_ff.mode;
                     cnt_in      = cnt_ff + CW'(1);
                     out_in.kind = rwlt_pkg::K_QUEUED;
                  end
               end
               rwlt_pkg::ACT_REL_RD, rwlt_pkg::ACT_REL_WR: begin
                  if (cur_ff.mode ? (rd_data != rwlt_pkg::WORD_WRITE)
                      : (rd_data == rwlt_pkg::WORD_IDLE || rd_data == rwlt_pkg::WORD_WRITE)) begin
                     out_v_in = 1'b1;
                     last_in  = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     pend_in      = echo;
                     pend_in.kind = rwlt_pkg::K_RELEASED;
                     state_in     = S_WALK;
                  end
               end
               default: begin
                  state_in = S_WALK;
               end
            endcase
         end
         S_WALK: begin
            if (p_ff >= cnt_ff) begin
               state_in = S_FIN;
            end else if (cur_ff.action == rwlt_pkg::ACT_CANCEL) begin
               if (v.entry == cur_ff.entry && v.requester == cur_ff.requester) begin
                  remove  = 1'b1;
                  drop_in = 1'b1;
               end else begin
                  p_in = p_ff + CW'(1);
               end
            end else if (v.entry != cur_ff.entry) begin
               p_in = p_ff + CW'(1);
            end else if (!ok) begin
               state_in = S_FIN;
            end else begin
               word_in          = new_w;
               first_in         = 1'b0;
               remove           = 1'b1;
               out_v_in         = 1'b1;
               out_in           = pend_ff;
               pend_in.kind     = rwlt_pkg::K_GRANT;
               pend_in.entry     = v.entry;
               pend_in.requester = v.requester;
               pend_in.slot      = v.slot;
               pend_in.mode      = v.mode;
            end
         end
         S_FIN: begin
            out_v_in = 1'b1;
            last_in  = 1'b1;
            state_in = S_IDLE;
            if (cur_ff.action == rwlt_pkg::ACT_CANCEL) begin
               out_in      = echo;
               out_in.kind = drop_ff ? rwlt_pkg::K_CANCEL : rwlt_pkg::K_NONE;
            end else begin
               out_in = pend_ff;
               wr_en  = 1'b1;
               if (first_ff) begin
                  wr_data = cur_ff.mode ? rwlt_pkg::WORD_IDLE : word_ff - 8'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // close the gap left by a removed waiter
      if (remove) begin
         cnt_in = cnt_ff - CW'(1);
         for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
            if (CW'(i) >= p_ff) begin
               q_in[i] = q_ff[i + 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         out_v_ff <= out_v_in;
      end
      cur_ff   <= cur_in;
      word_ff  <= word_in;
      p_ff     <= p_in;
      first_ff <= first_in;
      drop_ff  <= drop_in;
      q_ff     <= q_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
      last_ff  <= last_in;
   end

   assign clearing  = (state_ff == S_CLR);
   assign out_valid = out_v_ff;
   assign out_last  = last_ff;
   assign out_res   = out_ff;

endmodule

// ===== rtl/rw_lock_table_with_waiters.sv =====
// top level of the reader/writer lock table with a queue of waiters
// depends on rwlt_pkg, rwlt_front, rwlt_back, rwlt_ram and the assertion header
`timescale 1ns / 1ps
`include "rw_lock_table_with_waiters_assert.svh"

//  channel   handshake              payload
//  request   start high, busy low   req_action, req_entry, req_requester, req_slot
//  response  rsp_strobe, one cycle  rsp_kind, rsp_granted_entry, rsp_grant_requester,
//                                   rsp_grant_slot, rsp_grant_mode, rsp_last
//  config    csr_we                 csr_wdata (entry count)
//
// a transfer in is registered in the command queue before the back part takes it
// in the back part a bad command is answered from idle, an acquire or a misused release
// from the execute state; release and cancel then walk the waiters, answer in the finish
// state, and a waiter that cannot take the lock stops the hand-off walk early
// the lock word memory sets the pace: one read, then at most one write per command
// after reset a clearing pass zeroes all ENTRIES lock words, busy stays high
// a two deep command queue keeps start accepted while the back part works, until it is full
// responses cannot be stalled by the receiver

module rw_lock_table_with_waiters #(
   parameter int ENTRIES     = rwlt_pkg::ENTRIES_DEF,
   parameter int WAIT_DEPTH  = rwlt_pkg::WAIT_DEPTH_DEF,
   parameter int MAX_READERS = rwlt_pkg::MAX_READERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [9:0]  req_entry,
   input  logic [7:0]  req_requester,
   input  logic [7:0]  req_slot,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_kind,
   output logic [9:0]  rsp_granted_entry,
   output logic [7:0]  rsp_grant_requester,
   output logic [7:0]  rsp_grant_slot,
   output logic        rsp_grant_mode,
   output logic        rsp_last
);

   // reset value of the entry count, entries above 1023 are never addressed
   localparam int CNT_RST = (ENTRIES > 1024) ? 1024 : ENTRIES;

   logic [10:0]       entry_count_ff;
   logic              full, pop, clearing, accept;
   rwlt_pkg::fq_type  fq;
   rwlt_pkg::res_type res;

   // entry count register; the user must write it only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= 11'(CNT_RST);
      end else if (csr_we) begin
         entry_count_ff <= csr_wdata;
      end
   end

   // transfer in when the queue has room and the clearing pass is over
   assign busy   = full | clearing;
   assign accept = start & ~busy;

   rwlt_front #(.ENTRIES(ENTRIES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .action      (req_action),
      .entry       (req_entry),
      .requester   (req_requester),
      .slot        (req_slot),
      .entry_count (entry_count_ff),
      .pop         (pop),
      .full        (full),
      .fq          (fq)
   );

   rwlt_back #(
      .ENTRIES     (ENTRIES),
      .WAIT_DEPTH  (WAIT_DEPTH),
      .MAX_READERS (MAX_READERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .fq        (fq),
      .pop       (pop),
      .clearing  (clearing),
      .out_valid (rsp_strobe),
      .out_last  (rsp_last),
      .out_res   (res)
   );

   assign rsp_kind            = res.kind;
   assign rsp_granted_entry   = res.entry;
   assign rsp_grant_requester = res.requester;
   assign rsp_grant_slot      = res.slot;
   assign rsp_grant_mode      = res.mode;

   // the back part only takes a command that is there
   `RWLT_ASSERT_NOW(a_pop_avail, pop, fq.avail)
   // no transfer in while the lock words are being cleared
   `RWLT_ASSERT_NOW(a_clear_busy, clearing, busy)
   // a popped command never finishes in the very next cycle unless it was bad
   `RWLT_ASSERT_NEXT(a_good_pop_quiet, pop && !fq.head.bad, !rsp_strobe)

endmodule

// ===== tb/sv/rw_lock_table_with_waiters_checker.sv =====
// checker for the lock table: watches the request, config and response channels
// depends on rwlt_pkg for the action and result codes
`timescale 1ns / 1ps

module rw_lock_table_with_waiters_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_action,
   input  logic [9:0]  req_entry,
   input  logic [7:0]  req_requester,
   input  logic [7:0]  req_slot,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_kind,
   input  logic [9:0]  rsp_granted_entry,
   input  logic [7:0]  rsp_grant_requester,
   input  logic [7:0]  rsp_grant_slot,
   input  logic        rsp_grant_mode,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);
   import rwlt_pkg::*;

   localparam int NENT  = ENTRIES_DEF;
   localparam int NWAIT = WAIT_DEPTH_DEF;
   localparam int RCAP  = (MAX_READERS_DEF < 254) ? MAX_READERS_DEF : 254;

   typedef struct {
      logic [2:0] kind;
      logic [9:0] entry;
      logic [7:0] requester;
      logic [7:0] slot;
      logic       mode;
      logic       last;
   } outcome_type;

   outcome_type outcome_q[$];
   logic [7:0]  word_of[NENT];
   logic        wv[NWAIT];
   logic [9:0]  w_entry[NWAIT];
   logic [7:0]  w_req[NWAIT];
   logic [7:0]  w_slot[NWAIT];
   logic        w_mode[NWAIT];
   int          head;
   int          entry_limit;

   assign pending = outcome_q.size();

   function automatic int phys(int p);
      return (head + p) % NWAIT;
   endfunction

   function automatic int waiter_total();
      int n;
      n = 0;
      while (n < NWAIT && wv[phys(n)]) n++;
      return n;
   endfunction

   function automatic void drop_waiter(int p, int n);
      if (p == 0) begin
         wv[phys(0)] = 1'b0;
         head = phys(1);
         return;
      end
      for (int q = p; q + 1 < n; q++) begin
         wv[phys(q)]      = wv[phys(q + 1)];
         w_entry[phys(q)] = w_entry[phys(q + 1)];
         w_req[phys(q)]   = w_req[phys(q + 1)];
         w_slot[phys(q)]  = w_slot[phys(q + 1)];
         w_mode[phys(q)]  = w_mode[phys(q + 1)];
      end
      wv[phys(n - 1)] = 1'b0;
   endfunction

   function automatic void expect_out(logic [2:0] k, logic [9:0] e, logic [7:0] r,
                                      logic [7:0] s, logic m);
      outcome_type o;
      o.kind = k; o.entry = e; o.requester = r; o.slot = s; o.mode = m; o.last = 1'b0;
      outcome_q.push_back(o);
   endfunction

   // works out the responses of one accepted command and updates the lock state
   function automatic void lock_step(logic [2:0] act, logic [9:0] e, logic [7:0] r,
                                     logic [7:0] s);
      logic       m;
      logic [7:0] w;
      int         n, p, dropped;
      bit         first, ok, queued_here;
      m = (act < ACT_CANCEL) ? act[0] : 1'b0;
      if (act > ACT_CANCEL || int'(e) >= entry_limit) begin
         expect_out(K_BAD, e, r, s, m);
      end else if (act == ACT_ACQ_RD || act == ACT_ACQ_WR) begin
         w = word_of[e];
         n = waiter_total();
         queued_here = 0;
         for (p = 0; p < n; p++) if (w_entry[phys(p)] == e) queued_here = 1;
         if (w == WORD_IDLE) begin
            word_of[e] = m ? WORD_WRITE : 8'd1;
            expect_out(K_GRANT, e, r, s, m);
         end else if (!m && w != WORD_WRITE && int'(w) < RCAP && !queued_here) begin
            word_of[e] = w + 8'd1;
            expect_out(K_GRANT, e, r, s, m);
         end else if (n >= NWAIT) begin
            expect_out(K_FULL, e, r, s, m);
         end else begin
            wv[phys(n)] = 1'b1; w_entry[phys(n)] = e; w_req[phys(n)] = r;
            w_slot[phys(n)] = s; w_mode[phys(n)] = m;
            expect_out(K_QUEUED, e, r, s, m);
         end
      end else if (act == ACT_REL_RD || act == ACT_REL_WR) begin
         w = word_of[e];
         if (m ? (w != WORD_WRITE) : (w == WORD_IDLE || w == WORD_WRITE)) begin
            expect_out(K_BAD, e, r, s, m);
         end else begin
            expect_out(K_RELEASED, e, r, s, m);
            n = waiter_total();
            p = 0;
            first = 1;
            while (p < n) begin
               if (w_entry[phys(p)] != e) begin
                  p++;
                  continue;
               end
               w = word_of[e];
               if (first) begin
                  if (m) begin
                     ok = 1;
                     if (!w_mode[phys(p)]) w = 8'd1;
                  end else if (w_mode[phys(p)]) begin
                     // read to write exchange needs the last reader
                     ok = (w == 8'd1);
                     if (ok) w = WORD_WRITE;
                  end else begin
                     ok = 1;
                  end
               end else if (w_mode[phys(p)]) begin
                  ok = (w == WORD_IDLE);
                  if (ok) w = WORD_WRITE;
               end else begin
                  ok = (w != WORD_WRITE && int'(w) < RCAP);
                  if (ok) w = w + 8'd1;
               end
               if (!ok) break;
               word_of[e] = w;
               expect_out(K_GRANT, w_entry[phys(p)], w_req[phys(p)], w_slot[phys(p)],
                          w_mode[phys(p)]);
               drop_waiter(p, n);
               n--;
               first = 0;
            end
            if (first) word_of[e] = m ? WORD_IDLE : word_of[e] - 8'd1;
         end
      end else begin
         n = waiter_total();
         p = 0;
         dropped = 0;
         while (p < n) begin
            if (w_entry[phys(p)] == e && w_req[phys(p)] == r) begin
               drop_waiter(p, n);
               n--;
               dropped++;
            end else begin
               p++;
            end
         end
         expect_out(dropped ? K_CANCEL : K_NONE, e, r, s, 1'b0);
      end
      outcome_q[$].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         for (int i = 0; i < NENT; i++) word_of[i] = WORD_IDLE;
         for (int i = 0; i < NWAIT; i++) wv[i] = 1'b0;
         head        = 0;
         entry_limit = NENT;
         outcome_q.delete();
         fail_count  = 0;
      end else begin
         if (csr_we) entry_limit = int'(csr_wdata);
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected response kind %0d entry %0d requester %0d",
                        $time, rsp_kind, rsp_granted_entry, rsp_grant_requester);
               fail_count++;
            end else begin
               o = outcome_q.pop_front();
               if ({rsp_kind, rsp_granted_entry, rsp_grant_requester, rsp_grant_slot,
                    rsp_grant_mode, rsp_last} !==
                   {o.kind, o.entry, o.requester, o.slot, o.mode, o.last}) begin
                  $display("%0t: expected kind %0d entry %0d req %0d slot %0d mode %0d last %0d",
                           $time, o.kind, o.entry, o.requester, o.slot, o.mode, o.last);
                  $display("%0t: actual   kind %0d entry %0d req %0d slot %0d mode %0d last %0d",
                           $time, rsp_kind, rsp_granted_entry, rsp_grant_requester,
                           rsp_grant_slot, rsp_grant_mode, rsp_last);
                  fail_count++;
               end
            end
         end
         // transfer on the request channel
         if (start && !busy) lock_step(req_action, req_entry, req_requester, req_slot);
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the lock table: clock, reset, stimulus and the verdict
// depends on rwlt_pkg, the lock table rtl and rw_lock_table_with_waiters_checker
`timescale 1ns / 1ps

module tb;
   import rwlt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_action = '0;
   logic [9:0]  req_entry = '0;
   logic [7:0]  req_requester = '0;
   logic [7:0]  req_slot = '0;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_kind;
   logic [9:0]  rsp_granted_entry;
   logic [7:0]  rsp_grant_requester;
   logic [7:0]  rsp_grant_slot;
   logic        rsp_grant_mode;
   logic        rsp_last;
   int          fail_count;
   int          pending;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rw_lock_table_with_waiters DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_entry(req_entry),
      .req_requester(req_requester), .req_slot(req_slot),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind),
      .rsp_granted_entry(rsp_granted_entry), .rsp_grant_requester(rsp_grant_requester),
      .rsp_grant_slot(rsp_grant_slot), .rsp_grant_mode(rsp_grant_mode),
      .rsp_last(rsp_last)
   );

   rw_lock_table_with_waiters_checker lock_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_entry(req_entry),
      .req_requester(req_requester), .req_slot(req_slot),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind),
      .rsp_granted_entry(rsp_granted_entry), .rsp_grant_requester(rsp_grant_requester),
      .rsp_grant_slot(rsp_grant_slot), .rsp_grant_mode(rsp_grant_mode),
      .rsp_last(rsp_last), .fail_count(fail_count), .pending(pending)
   );

   // gap after a transfer: mostly none, some short, a few long
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return 0;
      if (pick < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // drive one command and hold it until the transfer happens
   task automatic issue(logic [2:0] act, logic [9:0] e, logic [7:0] r, logic [7:0] s);
      int gap;
      start         <= 1'b1;
      req_action    <= act;
      req_entry     <= e;
      req_requester <= r;
      req_slot      <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = gap_len();
      // a zero gap keeps start high for the next command
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait until every response has come
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // idle margin before the next step
      repeat (40) @(posedge clock);
   endtask

   task automatic set_entry_count(logic [10:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // random command aimed at a few entries and requesters so that waiters pile up
   task automatic random_cmd(int pool);
      int         pick;
      logic [2:0] act;
      logic [9:0] e;
      logic [7:0] r;
      pick = $urandom_range(99);
      if (pick < 45)      act = $urandom_range(1) ? ACT_ACQ_WR : ACT_ACQ_RD;
      else if (pick < 85) act = $urandom_range(1) ? ACT_REL_WR : ACT_REL_RD;
      else if (pick < 95) act = ACT_CANCEL;
      else                act = 3'($urandom_range(7, 5));
      e = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(pool - 1));
      r = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      issue(act, e, r, 8'($urandom_range(255)));
   endtask

   task automatic random_phase(int count, int pool);
      int         k;
      logic [9:0] e;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(19);
         if (k == 0) begin
            // hold one entry and overfill the waiter queue behind it
            e = 10'($urandom_range(pool - 1));
            issue(ACT_ACQ_WR, e, 8'($urandom_range(255)), 8'($urandom_range(255)));
            repeat (18) issue(3'($urandom_range(1)), e, 8'($urandom_range(255)),
                              8'($urandom_range(255)));
            repeat (6) issue($urandom_range(1) ? ACT_REL_WR : ACT_REL_RD, e,
                             8'($urandom_range(255)), 8'($urandom_range(255)));
         end else begin
            random_cmd(pool);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: sharing, exchange, misuse, bad actions, cancel
      issue(ACT_ACQ_RD, 10'd0, 8'd1, 8'd0);
      issue(ACT_ACQ_RD, 10'd0, 8'd2, 8'd255);
      issue(ACT_ACQ_WR, 10'd0, 8'd3, 8'd7);
      issue(ACT_ACQ_RD, 10'd0, 8'd4, 8'd8);
      issue(ACT_REL_WR, 10'd0, 8'd1, 8'd0);
      issue(ACT_REL_RD, 10'd0, 8'd1, 8'd0);
      issue(ACT_REL_RD, 10'd0, 8'd2, 8'd0);
      issue(ACT_REL_WR, 10'd0, 8'd3, 8'd0);
      issue(ACT_REL_RD, 10'd0, 8'd4, 8'd0);
      issue(ACT_REL_RD, 10'd2, 8'd5, 8'd1);
      issue(ACT_ACQ_WR, 10'd1023, 8'd255, 8'd255);
      issue(3'd5, 10'd1, 8'd0, 8'd0);
      issue(3'd6, 10'd1, 8'd0, 8'd0);
      issue(3'd7, 10'd1023, 8'd170, 8'd85);
      issue(ACT_ACQ_WR, 10'd3, 8'd8, 8'd1);
      issue(ACT_ACQ_WR, 10'd3, 8'd9, 8'd2);
      issue(ACT_ACQ_RD, 10'd3, 8'd10, 8'd3);
      issue(ACT_ACQ_RD, 10'd3, 8'd11, 8'd4);
      issue(ACT_CANCEL, 10'd3, 8'd9, 8'd0);
      issue(ACT_CANCEL, 10'd3, 8'd9, 8'd0);
      issue(ACT_REL_WR, 10'd3, 8'd8, 8'd0);
      issue(ACT_REL_WR, 10'd1023, 8'd255, 8'd0);

      // reader cap: fill one entry with readers, then queue behind it
      repeat (256) issue(ACT_ACQ_RD, 10'd5, 8'($urandom_range(255)), 8'($urandom_range(255)));
      issue(ACT_ACQ_WR, 10'd5, 8'd20, 8'd1);
      issue(ACT_ACQ_RD, 10'd5, 8'd21, 8'd2);
      repeat (3) issue(ACT_REL_RD, 10'd5, 8'd0, 8'd0);

      set_entry_count(11'd8);
      random_phase(20, 12);
      // sender holds off until the table has answered everything
      drain();
      random_phase(15, 12);
      set_entry_count(11'd1);
      random_phase(6, 3);
      set_entry_count(11'd0);
      random_phase(4, 2);
      set_entry_count(11'd2047);
      random_phase(10, 6);
      set_entry_count(11'd1024);
      random_phase(8, 6);

      drain();
      if (fail_count == 0) begin
         $display("rw_lock_table_with_waiters: match");
      end else begin
         $display("rw_lock_table_with_waiters: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("rw_lock_table_with_waiters: mismatch");
      $finish;
   end

endmodule
